// ===== hdl/hsv_rgb_color_converter_top_assert.svh =====
// Assertion macros for the color converter.
`ifndef HSV_RGB_COLOR_CONVERTER_TOP_ASSERT_SVH
`define HSV_RGB_COLOR_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define HRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HRC_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HRC_ASSERT(lbl, clk, rstn, prop, msg)
`define HRC_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hdl/hrc_pkg.sv =====
package hrc_pkg;

    localparam int QUO_BITS = 8;

    localparam logic [7:0] SECTOR         = 8'd43;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
    localparam logic [7:0] FULL_SCALE     = 8'd255;

    localparam logic MODE_HSV2RGB = 1'b0;
    localparam logic MODE_RGB2HSV = 1'b1;

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    localparam logic [2:0] REGION_0 = 3'd0;
    localparam logic [2:0] REGION_1 = 3'd1;
    localparam logic [2:0] REGION_2 = 3'd2;
    localparam logic [2:0] REGION_3 = 3'd3;
    localparam logic [2:0] REGION_4 = 3'd4;
    localparam logic [2:0] REGION_5 = 3'd5;

    // Work word carried down the divider chain; each mode uses its own fields.
    typedef struct packed {
        logic        mode;
        logic [7:0]  v;
        logic [7:0]  s;
        logic [2:0]  region;
        logic [7:0]  sr;
        logic [7:0]  st;
        logic [7:0]  mx;
        logic [1:0]  sel;
        logic        neg;
        logic        grey;
        logic [15:0] r1;
        logic [7:0]  d1;
        logic [7:0]  q1;
        logic [13:0] r2;
        logic [7:0]  d2;
        logic [7:0]  q2;
    } t_work;

endpackage

// ===== hdl/hrc_front.sv =====
module hrc_front
    import hrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic [7:0] i_in_first,
    input  logic [7:0] i_in_second,
    input  logic [7:0] i_in_third,
    output logic       o_valid,
    input  logic       i_ready,
    output t_work      o_work
);

    logic        r_valid;
    t_work       r_work;
    t_work       n_work;
    logic [7:0]  start;
    logic [7:0]  hd;
    logic [10:0] rem_w;
    logic [7:0]  rem;
    logic [15:0] prod_sr;
    logic [15:0] prod_st;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [8:0]  diff;
    logic [7:0]  mag;
    logic [13:0] r2_w;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_comb begin
        // hue sector by compare chain
        priority if (i_in_first < SECTOR) begin
            n_work.region = REGION_0; start = 8'd0;
        end else if (i_in_first < 8'd86) begin
            n_work.region = REGION_1; start = 8'd43;
        end else if (i_in_first < 8'd129) begin
            n_work.region = REGION_2; start = 8'd86;
        end else if (i_in_first < 8'd172) begin
            n_work.region = REGION_3; start = 8'd129;
        end else if (i_in_first < 8'd215) begin
            n_work.region = REGION_4; start = 8'd172;
        end else begin
            n_work.region = REGION_5; start = 8'd215;
        end
        hd      = i_in_first - start;
        rem_w   = {3'b0, hd} * 11'd6;
        rem     = rem_w[7:0];
        prod_sr = {8'b0, i_in_second} * {8'b0, rem};
        prod_st = {8'b0, i_in_second} * {8'b0, FULL_SCALE - rem};

        mx = i_in_first;
        mn = i_in_first;
        if (i_in_second > mx) mx = i_in_second;
        if (i_in_third > mx)  mx = i_in_third;
        if (i_in_second < mn) mn = i_in_second;
        if (i_in_third < mn)  mn = i_in_third;
        d = mx - mn;

        // ties go to red, then green
        priority if (mx == i_in_first) begin
            n_work.sel = SEL_RED;
            diff = {1'b0, i_in_second} - {1'b0, i_in_third};
        end else if (mx == i_in_second) begin
            n_work.sel = SEL_GREEN;
            diff = {1'b0, i_in_third} - {1'b0, i_in_first};
        end else begin
            n_work.sel = SEL_BLUE;
            diff = {1'b0, i_in_first} - {1'b0, i_in_second};
        end
        mag  = diff[8] ? 8'(-diff) : diff[7:0];
        r2_w = {6'b0, mag} * 14'd43;

        n_work.mode = i_mode;
        n_work.v    = i_in_third;
        n_work.s    = i_in_second;
        n_work.sr   = prod_sr[15:8];
        n_work.st   = prod_st[15:8];
        n_work.mx   = mx;
        n_work.neg  = diff[8];
        n_work.grey = (d == 8'd0);
        n_work.r1   = {d, 8'b0} - {8'b0, d};
        n_work.d1   = mx;
        n_work.q1   = '0;
        n_work.r2   = r2_w;
        n_work.d2   = d;
        n_work.q2   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== hdl/hrc_div_cell.sv =====
module hrc_div_cell
    import hrc_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    logic        r_valid;
    t_work       r_work;
    t_work       n_work;
    logic [15:0] ds1;
    logic [15:0] ds2;
    logic [15:0] r2x;
    logic [15:0] r2n;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    // one quotient bit of each division
    always_comb begin
        n_work = i_work;
        ds1    = {8'b0, i_work.d1} << BIT;
        ds2    = {8'b0, i_work.d2} << BIT;
        r2x    = {2'b0, i_work.r2};
        r2n    = r2x - ds2;
        if (i_work.r1 >= ds1) begin
            n_work.r1     = i_work.r1 - ds1;
            n_work.q1[BIT] = 1'b1;
        end
        if (r2x >= ds2) begin
            n_work.r2      = r2n[13:0];
            n_work.q2[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== hdl/hrc_back.sv =====
module hrc_back
    import hrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_work      i_work,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_mode,
    output logic [7:0] o_out_first,
    output logic [7:0] o_out_second,
    output logic [7:0] o_out_third
);

    logic        r_valid;
    logic        r_mode;
    logic [7:0]  r_first;
    logic [7:0]  r_second;
    logic [7:0]  r_third;
    logic [7:0]  n_first;
    logic [7:0]  n_second;
    logic [7:0]  n_third;
    logic [15:0] pp;
    logic [15:0] pq;
    logic [15:0] pt;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  v;
    logic [7:0]  base;
    logic [7:0]  off;

    assign o_ready      = !r_valid || !i_stall;
    assign o_valid      = r_valid;
    assign o_mode       = r_mode;
    assign o_out_first  = r_first;
    assign o_out_second = r_second;
    assign o_out_third  = r_third;

    always_comb begin
        v  = i_work.v;
        pp = {8'b0, v} * {8'b0, FULL_SCALE - i_work.s};
        pq = {8'b0, v} * {8'b0, FULL_SCALE - i_work.sr};
        pt = {8'b0, v} * {8'b0, FULL_SCALE - i_work.st};
        p  = pp[15:8];
        q  = pq[15:8];
        t  = pt[15:8];

        unique case (i_work.sel)
            SEL_GREEN: base = HUE_BASE_GREEN;
            SEL_BLUE:  base = HUE_BASE_BLUE;
            default:   base = 8'd0;
        endcase
        off = i_work.neg ? (8'd0 - i_work.q2) : i_work.q2;

        if (i_work.mode == MODE_RGB2HSV) begin
            n_third  = i_work.mx;
            n_second = (i_work.mx == 8'd0) ? 8'd0 : i_work.q1;
            n_first  = i_work.grey ? 8'd0 : base + off;
        end else if (i_work.s == 8'd0) begin
            n_first  = v;
            n_second = v;
            n_third  = v;
        end else begin
            unique case (i_work.region)
                REGION_0: begin n_first = v; n_second = t; n_third = p; end
                REGION_1: begin n_first = q; n_second = v; n_third = p; end
                REGION_2: begin n_first = p; n_second = v; n_third = t; end
                REGION_3: begin n_first = p; n_second = q; n_third = v; end
                REGION_4: begin n_first = t; n_second = p; n_third = v; end
                default:  begin n_first = v; n_second = p; n_third = q; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_mode   <= i_work.mode;
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
        end
    end

endmodule

// ===== hdl/hsv_rgb_color_converter_top.sv =====
// 8-bit HSV/RGB color converter, direction chosen per item by i_mode. Fully
// pipelined: one item per clock while i_stall is low, through an input stage, a chain of
// eight divider cells that each resolve one quotient bit of the saturation and
// hue divisions, and an output stage. Stages hold independently, so the
// pipeline keeps filling while a finished item waits at the output.
`include "hsv_rgb_color_converter_top_assert.svh"

module hsv_rgb_color_converter_top
    import hrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [7:0] i_in_first,
    input  logic [7:0] i_in_second,
    input  logic [7:0] i_in_third,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_first,
    output logic [7:0] o_out_second,
    output logic [7:0] o_out_third
);

    logic                front_ready;
    logic [QUO_BITS:0]   cv;
    logic [QUO_BITS:0]   cr;
    t_work               cw [QUO_BITS+1];
    logic                out_mode;

    assign o_stall = !front_ready;

    hrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (front_ready),
        .i_mode      (i_mode),
        .i_in_first  (i_in_first),
        .i_in_second (i_in_second),
        .i_in_third  (i_in_third),
        .o_valid     (cv[0]),
        .i_ready     (cr[0]),
        .o_work      (cw[0])
    );

    // quotient bits resolved MSB first
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
        hrc_div_cell #(.BIT(QUO_BITS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[k]),
            .o_ready (cr[k]),
            .i_work  (cw[k]),
            .o_valid (cv[k+1]),
            .i_ready (cr[k+1]),
            .o_work  (cw[k+1])
        );
    end

    hrc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (cv[QUO_BITS]),
        .o_ready      (cr[QUO_BITS]),
        .i_work       (cw[QUO_BITS]),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mode       (out_mode),
        .o_out_first  (o_out_first),
        .o_out_second (o_out_second),
        .o_out_third  (o_out_third)
    );

    `HRC_NEVER(a_stall_needs_full_front, i_clk, i_rst_n, o_stall && !cv[0], "stall with empty input stage")
    `HRC_NEVER(a_grey_hue_zero, i_clk, i_rst_n, o_valid && out_mode == MODE_RGB2HSV && o_out_second == 8'd0 && o_out_first != 8'd0, "nonzero hue at zero saturation")
    `HRC_ASSERT(a_full_chain_holds, i_clk, i_rst_n, (o_valid && i_stall && cv[QUO_BITS]) |=> cv[QUO_BITS], "chain item lost")

endmodule
